>>> rtl/core/cpos_pkg.sv
// ----------------------------------------------------------------------------
// cpos_pkg
// Shared types and constants for the closest-point-on-segment pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cpos_pkg;

   localparam int COORD_W   = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int T_FRAC    = 30;
   localparam int T_W       = T_FRAC + 1;
   localparam int SCALE_W   = T_W + 1 + DIFF_W;
   localparam int NUM_AXES  = 3;
   localparam int NUM_CELLS = T_FRAC;
   localparam int FRONT_LAT = 4;
   localparam int BACK_LAT  = 2;
   localparam int LATENCY   = FRONT_LAT + NUM_CELLS + BACK_LAT;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;

   typedef enum logic [1:0] {
      MODE_DIV,
      MODE_ZERO,
      MODE_ONE,
      MODE_DEGEN
   } mode_type;

   // Transaction record handed from cell to cell
   typedef struct packed {
      logic                        valid;
      mode_type                    mode;
      logic [NUM_AXES-1:0][COORD_W-1:0] start;
      logic [NUM_AXES-1:0][DIFF_W-1:0]  dir;
      logic [SUM_W-1:0]            len2;
      logic [SUM_W-1:0]            rem;
      logic [T_W-1:0]              quo;
   } cell_type;

endpackage

`default_nettype wire

>>> rtl/core/cpos_front.sv
// ----------------------------------------------------------------------------
// cpos_front
// Differences, dot product and squared length, then t classification.
// ----------------------------------------------------------------------------
`default_nettype none

module cpos_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   input  wire logic [cpos_pkg::NUM_AXES-1:0][cpos_pkg::COORD_W-1:0] in_start,
   input  wire logic [cpos_pkg::NUM_AXES-1:0][cpos_pkg::COORD_W-1:0] in_end,
   input  wire logic [cpos_pkg::NUM_AXES-1:0][cpos_pkg::COORD_W-1:0] in_probe,
   output cpos_pkg::cell_type                          cell_out
);
   import cpos_pkg::*;

   logic                                  v1_ff, v2_ff, v3_ff;
   logic [NUM_AXES-1:0][COORD_W-1:0]      s1_ff, s2_ff, s3_ff;
   logic [NUM_AXES-1:0][DIFF_W-1:0]       d1_ff, d2_ff, d3_ff, a1_ff;
   logic [NUM_AXES-1:0][PROD_W-1:0]       ad_ff, dd_ff;
   logic [SUM_W-1:0]                      dot_ff, len2_ff;
   logic [SUM_W-1:0]                      dot_in, len2_in;
   cell_type                              cell_ff, cell_in;

   always_comb begin
      dot_in  = '0;
      len2_in = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         dot_in  = dot_in  + SUM_W'($signed(ad_ff[i]));
         len2_in = len2_in + SUM_W'($signed(dd_ff[i]));
      end
   end

   always_comb begin
      cell_in       = '0;
      // valid is cleared synchronously while reset is high
      cell_in.valid = v3_ff && !reset;
      cell_in.start = s3_ff;
      cell_in.dir   = d3_ff;
      cell_in.len2  = len2_ff;
      cell_in.rem   = dot_ff;
      cell_in.quo   = '0;
      // dot is signed, len2 is never negative
      priority if (len2_ff == '0)
         cell_in.mode = MODE_DEGEN;
      else if (dot_ff[SUM_W-1] || dot_ff == '0)
         cell_in.mode = MODE_ZERO;
      else if (dot_ff >= len2_ff)
         cell_in.mode = MODE_ONE;
      else
         cell_in.mode = MODE_DIV;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
      end else begin
         v1_ff         <= in_valid;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_AXES; i++) begin
         s1_ff[i] <= in_start[i];
         d1_ff[i] <= DIFF_W'($signed(in_end[i]))   - DIFF_W'($signed(in_start[i]));
         a1_ff[i] <= DIFF_W'($signed(in_probe[i])) - DIFF_W'($signed(in_start[i]));
         ad_ff[i] <= $signed(a1_ff[i]) * $signed(d1_ff[i]);
         dd_ff[i] <= $signed(d1_ff[i]) * $signed(d1_ff[i]);
      end
      s2_ff   <= s1_ff;
      d2_ff   <= d1_ff;
      s3_ff   <= s2_ff;
      d3_ff   <= d2_ff;
      dot_ff  <= dot_in;
      len2_ff <= len2_in;
      cell_ff <= cell_in;
   end

   assign cell_out = cell_ff;

endmodule

`default_nettype wire

>>> rtl/core/cpos_div_cell.sv
// ----------------------------------------------------------------------------
// cpos_div_cell
// One restoring-division step: develops one quotient bit of t.
// ----------------------------------------------------------------------------
`default_nettype none

module cpos_div_cell (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cpos_pkg::cell_type cell_in,
   output cpos_pkg::cell_type cell_out
);
   import cpos_pkg::*;

   cell_type         cell_ff, next_in;
   logic [SUM_W:0]   shifted;
   logic             ge;

   always_comb begin
      shifted = {cell_in.rem, 1'b0};
      ge      = shifted >= {1'b0, cell_in.len2};
      next_in = cell_in;
      // valid is cleared synchronously while reset is high
      next_in.valid = cell_in.valid && !reset;
      next_in.rem = ge ? SUM_W'(shifted - {1'b0, cell_in.len2}) : shifted[SUM_W-1:0];
      next_in.quo = {cell_in.quo[T_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      cell_ff <= next_in;
   end

   assign cell_out = cell_ff;

   // partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cell_ff.valid && cell_ff.mode == MODE_DIV) |-> (cell_ff.rem < cell_ff.len2))
      else $error("division remainder out of range");

endmodule

`default_nettype wire

>>> rtl/core/cpos_back.sv
// ----------------------------------------------------------------------------
// cpos_back
// Scales the direction by t, rounds, adds the start point and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module cpos_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cpos_pkg::cell_type cell_in,
   output logic                                   out_valid,
   output logic [cpos_pkg::NUM_AXES-1:0][cpos_pkg::COORD_W-1:0] out_near,
   output logic                                   out_degenerate
);
   import cpos_pkg::*;

   localparam int SUMQ_W = SCALE_W - T_FRAC + 2;

   logic                               v1_ff, v2_ff, deg1_ff, deg2_ff;
   logic [NUM_AXES-1:0][COORD_W-1:0]   s1_ff, near_ff, near_in;
   logic [NUM_AXES-1:0][SCALE_W-1:0]   prod_ff;
   logic [T_W-1:0]                     t_sel;
   logic [SCALE_W-1:0]                 rounded;
   logic [SCALE_W-T_FRAC-1:0]          q;
   logic [SUMQ_W-1:0]                  n;

   always_comb begin
      unique case (cell_in.mode)
         MODE_DIV:   t_sel = cell_in.quo;
         MODE_ONE:   t_sel = T_W'(1) << T_FRAC;
         MODE_ZERO:  t_sel = '0;
         MODE_DEGEN: t_sel = '0;
         default:    t_sel = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         rounded = prod_ff[i] + (SCALE_W'(1) << (T_FRAC - 1));
         q       = rounded[SCALE_W-1:T_FRAC];          // floor via arithmetic shift
         n       = SUMQ_W'($signed(s1_ff[i])) + SUMQ_W'($signed(q));
         priority if ($signed(n) > $signed(SUMQ_W'({1'b0, {(COORD_W-1){1'b1}}})))
            near_in[i] = {1'b0, {(COORD_W-1){1'b1}}};
         else if ($signed(n) < $signed({{(SUMQ_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}}))
            near_in[i] = {1'b1, {(COORD_W-1){1'b0}}};
         else
            near_in[i] = n[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cell_in.valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_AXES; i++) begin
         prod_ff[i] <= $signed({1'b0, t_sel}) * $signed(cell_in.dir[i]);
      end
      s1_ff   <= cell_in.start;
      deg1_ff <= (cell_in.mode == MODE_DEGEN);
      near_ff <= near_in;
      deg2_ff <= deg1_ff;
   end

   assign out_valid      = v2_ff;
   assign out_near       = near_ff;
   assign out_degenerate = deg2_ff;

   // a zero-length segment returns its start point
   a_degen_start: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && deg2_ff) |-> (near_ff == $past(s1_ff)))
      else $error("degenerate segment did not return start");

endmodule

`default_nettype wire

>>> rtl/core/closest_point_on_segment_3d_top.sv
// ----------------------------------------------------------------------------
// closest_point_on_segment_3d_top
// Nearest point on a 3D segment to a probe point, signed fixed point.
// ----------------------------------------------------------------------------
// Pipeline: start passes through the front stages, the divider cells and the back stages to rsp_valid.
// Throughput: one transaction per cycle; busy is always low.
// The 30-cell divider chain develops one bit of t per cell.
// Reset clears only the valid bits of the pipeline; results cannot be stalled.
`default_nettype none

module closest_point_on_segment_3d_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [cpos_pkg::COORD_W-1:0] req_seg_start_x,
   input  wire logic [cpos_pkg::COORD_W-1:0] req_seg_start_y,
   input  wire logic [cpos_pkg::COORD_W-1:0] req_seg_start_z,
   input  wire logic [cpos_pkg::COORD_W-1:0] req_seg_end_x,
   input  wire logic [cpos_pkg::COORD_W-1:0] req_seg_end_y,
   input  wire logic [cpos_pkg::COORD_W-1:0] req_seg_end_z,
   input  wire logic [cpos_pkg::COORD_W-1:0] req_probe_x,
   input  wire logic [cpos_pkg::COORD_W-1:0] req_probe_y,
   input  wire logic [cpos_pkg::COORD_W-1:0] req_probe_z,
   output logic                           rsp_valid,
   output logic [cpos_pkg::COORD_W-1:0]   rsp_near_x,
   output logic [cpos_pkg::COORD_W-1:0]   rsp_near_y,
   output logic [cpos_pkg::COORD_W-1:0]   rsp_near_z,
   output logic                           rsp_degenerate
);
   import cpos_pkg::*;

   logic                             accept;
   logic [NUM_AXES-1:0][COORD_W-1:0] in_start, in_end, in_probe, near;
   cell_type                         chain [NUM_CELLS+1];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign in_start = {req_seg_start_z, req_seg_start_y, req_seg_start_x};
   assign in_end   = {req_seg_end_z, req_seg_end_y, req_seg_end_x};
   assign in_probe = {req_probe_z, req_probe_y, req_probe_x};

   cpos_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_start (in_start),
      .in_end   (in_end),
      .in_probe (in_probe),
      .cell_out (chain[0])
   );

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      cpos_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   cpos_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cell_in        (chain[NUM_CELLS]),
      .out_valid      (rsp_valid),
      .out_near       (near),
      .out_degenerate (rsp_degenerate)
   );

   assign rsp_near_x = near[0];
   assign rsp_near_y = near[1];
   assign rsp_near_z = near[2];

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted transaction produced no response");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without a matching transaction");

endmodule

`default_nettype wire
